### hdl/pctc_pkg.sv
package pctc_pkg;

    // Fixed field widths of the channels
    localparam int CODE_W = 32;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;

    // Longest code that a table slot can hold
    localparam logic [LEN_W-1:0] CODE_MAX_LEN = 6'd32;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_CODE     = 2'd0,
        KIND_SYMBOL   = 2'd1,
        KIND_MISS     = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_back_state;

    // Classified command as it travels from the front through the queue
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              bit_val;
    } t_cmd;

    // Handshake between queue and its neighbors
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

### hdl/pctc_if.sv
interface pctc_in_if import pctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [IDX_W-1:0]  entry_index;
    logic [SYM_W-1:0]  entry_symbol;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic [SYM_W-1:0]  symbol_in;
    logic              bit_in;

    modport source (output valid, op, entry_index, entry_symbol, entry_code,
                    entry_length, symbol_in, bit_in, input ready);
    modport sink   (input valid, op, entry_index, entry_symbol, entry_code,
                    entry_length, symbol_in, bit_in, output ready);
endinterface

interface pctc_out_if import pctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  symbol_out;

    modport source (output valid, kind, code_word, code_length, symbol_out,
                    input ready);
    modport sink   (input valid, kind, code_word, code_length, symbol_out,
                    output ready);
endinterface

### hdl/pctc_front.sv
module pctc_front import pctc_pkg::*; (
    pctc_in_if.sink i_in,
    input  logic    i_push_ready,
    output t_cmd    o_cmd,
    output logic    o_push
);

    // Accept a beat whenever the queue has room
    assign i_in.ready = i_push_ready;
    assign o_push     = i_in.valid & i_push_ready;

    // Classify the beat: pick the symbol field its op needs and saturate the length
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = t_op'(i_in.op);
        o_cmd.idx     = i_in.entry_index;
        o_cmd.code    = i_in.entry_code;
        o_cmd.bit_val = i_in.bit_in;
        o_cmd.len     = (i_in.entry_length > CODE_MAX_LEN) ? CODE_MAX_LEN
                                                           : i_in.entry_length;
        unique case (t_op'(i_in.op))
            OP_ENCODE: o_cmd.sym = i_in.symbol_in;
            OP_LOAD:   o_cmd.sym = i_in.entry_symbol;
            default:   o_cmd.sym = '0;
        endcase
    end

endmodule

### hdl/pctc_queue.sv
module pctc_queue import pctc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_push,
    input  logic i_pop,
    output t_hs  o_stat,
    output t_cmd o_head
);

    // Two-entry queue between front and back
    t_cmd       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_stat.valid = (r_count != 2'd0);
    assign o_stat.ready = (r_count != 2'd2);
    assign o_head       = r_slot[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hdl/pctc_back.sv
module pctc_back import pctc_pkg::*; #(
    parameter int TABLE_SIZE = 32,
    parameter int MAX_LEN    = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_hs      i_q_stat,
    input  t_cmd     i_head,
    output logic     o_pop,
    pctc_out_if.source o_out
);

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (LW > LEN_W) ? LW : LEN_W;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;

    logic [SYM_W-1:0]  r_tab_sym  [TABLE_SIZE];
    logic [CODE_W-1:0] r_tab_code [TABLE_SIZE];
    logic [LEN_W-1:0]  r_tab_len  [TABLE_SIZE];

    logic [CODE_W-1:0]     r_acc_code, n_acc_code;
    logic [LW-1:0]         r_acc_len, n_acc_len;
    logic [TABLE_SIZE-1:0] r_hit, n_hit;
    logic [TABLE_SIZE-1:0] hit_sel;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [CODE_W-1:0] r_out_code;
    logic [LEN_W-1:0]  r_out_len;
    logic [SYM_W-1:0]  r_out_sym;

    logic              out_free, hit_any, acc_ovf, emit_need;
    logic              tab_we, hit_we, acc_shift, acc_clear, out_we;
    t_kind             res_kind;
    logic [CODE_W-1:0] res_code, sel_code;
    logic [LEN_W-1:0]  res_len, sel_len;
    logic [SYM_W-1:0]  res_sym, sel_sym;

    assign out_free  = !r_out_valid || o_out.ready;
    assign hit_any   = |r_hit;
    assign acc_ovf   = (r_acc_len >= LW'(MAX_LEN));
    assign emit_need = (r_cmd.op != OP_DECODE) || hit_any || acc_ovf;

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_stat.valid) n_state = ST_EXEC;
            ST_EXEC: n_state = (r_cmd.op == OP_LOAD) ? ST_IDLE : ST_EMIT;
            ST_EMIT: if (!emit_need || out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop     = 1'b0;
        tab_we    = 1'b0;
        hit_we    = 1'b0;
        acc_shift = 1'b0;
        acc_clear = 1'b0;
        out_we    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = i_q_stat.valid;
            ST_EXEC: begin
                tab_we    = (r_cmd.op == OP_LOAD);
                hit_we    = 1'b1;
                acc_shift = (r_cmd.op == OP_DECODE);
            end
            ST_EMIT: begin
                out_we    = emit_need && out_free;
                acc_clear = out_free && (r_cmd.op == OP_DECODE) && (hit_any || acc_ovf);
            end
            default: o_pop = 1'b0;
        endcase
    end

    // Compare every slot against the symbol or the shifted accumulator
    always_comb begin
        n_acc_code = {r_acc_code[CODE_W-2:0], r_cmd.bit_val};
        n_acc_len  = r_acc_len + LW'(1);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (r_cmd.op == OP_DECODE) begin
                n_hit[i] = (r_tab_code[i] == n_acc_code) &&
                           (CMP_W'(r_tab_len[i]) == CMP_W'(n_acc_len));
            end else begin
                n_hit[i] = (r_tab_len[i] != '0) && (r_tab_sym[i] == r_cmd.sym);
            end
        end
    end

    // Pick the lowest matching slot
    always_comb begin
        hit_sel  = r_hit & (~r_hit + TABLE_SIZE'(1));
        sel_code = '0;
        sel_len  = '0;
        sel_sym  = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            sel_code = sel_code | (hit_sel[i] ? r_tab_code[i] : '0);
            sel_len  = sel_len  | (hit_sel[i] ? r_tab_len[i]  : '0);
            sel_sym  = sel_sym  | (hit_sel[i] ? r_tab_sym[i]  : '0);
        end
    end

    // Build the result beat
    always_comb begin
        res_kind = KIND_CODE;
        res_code = '0;
        res_len  = '0;
        res_sym  = '0;
        unique case (r_cmd.op)
            OP_ENCODE: begin
                if (hit_any) begin
                    res_code = sel_code;
                    res_len  = sel_len;
                end else begin
                    res_kind = KIND_MISS;
                end
            end
            OP_DECODE: begin
                if (hit_any) begin
                    res_kind = KIND_SYMBOL;
                    res_sym  = sel_sym;
                end else begin
                    res_kind = KIND_OVERFLOW;
                end
            end
            OP_END: begin
                res_code = r_tab_code[TABLE_SIZE-1];
                res_len  = r_tab_len[TABLE_SIZE-1];
            end
            default: res_kind = KIND_CODE;
        endcase
    end

    // Control state, table and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_acc_code  <= '0;
            r_acc_len   <= '0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_tab_sym[i]  <= '0;
                r_tab_code[i] <= '0;
                r_tab_len[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_we) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (acc_shift) begin
                r_acc_code <= n_acc_code;
                r_acc_len  <= n_acc_len;
            end else if (acc_clear) begin
                r_acc_code <= '0;
                r_acc_len  <= '0;
            end
            for (int i = 0; i < TABLE_SIZE; i++) begin
                if (tab_we && (8'(r_cmd.idx) == 8'(i))) begin
                    r_tab_sym[i]  <= r_cmd.sym;
                    r_tab_code[i] <= r_cmd.code;
                    r_tab_len[i]  <= r_cmd.len;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (hit_we) begin
            r_hit <= n_hit;
        end
        if (out_we) begin
            r_out_kind <= res_kind;
            r_out_code <= res_code;
            r_out_len  <= res_len;
            r_out_sym  <= res_sym;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.code_word   = r_out_code;
    assign o_out.code_length = r_out_len;
    assign o_out.symbol_out  = r_out_sym;

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_clear |=> (r_acc_len == '0) && (r_acc_code == '0))
        else $error("accumulator not cleared after match or overflow");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_len <= LW'(MAX_LEN))
        else $error("accumulator length above maximum");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ($onehot0(hit_sel) && ((hit_sel != '0) == hit_any)))
        else $error("slot selection not one-hot");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tab_len[TABLE_SIZE-1] <= CODE_MAX_LEN)
        else $error("stored code length above limit");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !out_we)
        else $error("result written over a waiting beat");

endmodule

### hdl/prefix_code_table_codec_unit.sv
// Prefix-code table codec.
// Input channel i_in carries one command per beat: load a table slot, encode
// a symbol, shift in one decode bit, or emit the end marker (code of the last
// slot). Output channel o_out carries at most one result per command: a code
// word, a decoded symbol, an encode miss or a decode overflow.
// A beat is taken when valid and ready are both high on either channel.
// The front classifies each beat into a two-entry queue; the back sequencer
// pops one command, compares it against every slot at once, then picks the
// lowest matching slot and writes the output register (a load writes its slot).
// The back takes a new command only once it is through with the last one,
// stepping through its pop, compare and select steps; a load skips select.
// Reset clears the whole table (every slot unused), the decode accumulator
// and the queue.
// When o_out stalls, the result is held in the output register, the back
// waits on its next result, the queue fills and then i_in.ready drops.
module prefix_code_table_codec_unit import pctc_pkg::*; #(
    parameter int TABLE_SIZE = 32,
    parameter int MAX_LEN    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pctc_in_if.sink    i_in,
    pctc_out_if.source o_out
);

    t_cmd front_cmd;
    t_cmd q_head;
    t_hs  q_stat;
    logic push;
    logic pop;

    pctc_front u_front (
        .i_in         (i_in),
        .i_push_ready (q_stat.ready),
        .o_cmd        (front_cmd),
        .o_push       (push)
    );

    pctc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    pctc_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_LEN    (MAX_LEN)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (q_head),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pctc_pkg::*;

    localparam int SLOTS          = 32;
    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_SPACING   = 200;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_op               op;
        logic [IDX_W-1:0]  entry_index;
        logic [SYM_W-1:0]  entry_symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
        logic [SYM_W-1:0]  symbol_in;
        logic              bit_in;
    } t_command;

    typedef struct {
        t_kind             kind;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol_out;
    } t_reply;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_COIN,
        PACE_SPARSE,
        PACE_COMB
    } t_pace;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pctc_in_if  in_ch ();
    pctc_out_if out_ch ();

    prefix_code_table_codec_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Stimulus and scoreboard storage
    t_command commands_to_send[$];
    t_reply   replies_due[$];

    // Predicted block state
    logic [SYM_W-1:0]  slot_symbol [SLOTS];
    logic [CODE_W-1:0] slot_code   [SLOTS];
    logic [LEN_W-1:0]  slot_length [SLOTS];
    logic [CODE_W-1:0] shift_code   = '0;
    logic [LEN_W-1:0]  shift_length = '0;

    // Prefix code last loaded by the generator
    logic [CODE_W-1:0] leaf_code [SLOTS];
    logic [LEN_W-1:0]  leaf_len  [SLOTS];
    logic [SYM_W-1:0]  leaf_sym  [SLOTS];
    int                leaf_count = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver pacing
    int    results_taken = 0;
    int    next_hold_at  = 60;
    int    hold_left     = 0;
    int    pace_left     = 0;
    t_pace pace_mode     = PACE_FREE;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_symbol[s] = '0;
            slot_code[s]   = '0;
            slot_length[s] = '0;
        end
    end

    // Predict the reply of one accepted command and update the state copy
    task automatic compute_codec_reply(input t_command c);
        t_reply r;
        bit     hit;
        r.kind        = KIND_CODE;
        r.code_word   = '0;
        r.code_length = '0;
        r.symbol_out  = '0;
        hit           = 1'b0;
        case (c.op)
            OP_LOAD: begin
                slot_symbol[c.entry_index] = c.entry_symbol;
                slot_code[c.entry_index]   = c.entry_code;
                slot_length[c.entry_index] = (c.entry_length > CODE_MAX_LEN) ?
                                             CODE_MAX_LEN : c.entry_length;
            end
            OP_ENCODE: begin
                r.kind = KIND_MISS;
                for (int s = 0; s < SLOTS && !hit; s++) begin
                    if (slot_length[s] != '0 && slot_symbol[s] == c.symbol_in) begin
                        hit           = 1'b1;
                        r.kind        = KIND_CODE;
                        r.code_word   = slot_code[s];
                        r.code_length = slot_length[s];
                    end
                end
                replies_due.push_back(r);
            end
            OP_DECODE: begin
                shift_code   = {shift_code[CODE_W-2:0], c.bit_in};
                shift_length = shift_length + 1'b1;
                for (int s = 0; s < SLOTS && !hit; s++) begin
                    if (slot_code[s] == shift_code && slot_length[s] == shift_length) begin
                        hit          = 1'b1;
                        r.kind       = KIND_SYMBOL;
                        r.symbol_out = slot_symbol[s];
                    end
                end
                // no slot matched at the longest code: flag and start over
                if (!hit && shift_length >= CODE_MAX_LEN) begin
                    hit    = 1'b1;
                    r.kind = KIND_OVERFLOW;
                end
                if (hit) begin
                    shift_code   = '0;
                    shift_length = '0;
                    replies_due.push_back(r);
                end
            end
            default: begin
                r.code_word   = slot_code[SLOTS-1];
                r.code_length = slot_length[SLOTS-1];
                replies_due.push_back(r);
            end
        endcase
    endtask

    // Random filler so that fields an op ignores still toggle
    function automatic t_command random_command();
        t_command c;
        c.op           = t_op'($urandom_range(0, 3));
        c.entry_index  = IDX_W'($urandom);
        c.entry_symbol = SYM_W'($urandom);
        c.entry_code   = $urandom;
        c.entry_length = LEN_W'($urandom);
        c.symbol_in    = SYM_W'($urandom);
        c.bit_in       = 1'($urandom);
        return c;
    endfunction

    task automatic push_load(input int idx, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        t_command c;
        c              = random_command();
        c.op           = OP_LOAD;
        c.entry_index  = IDX_W'(idx);
        c.entry_symbol = sym;
        c.entry_code   = code;
        c.entry_length = len;
        commands_to_send.push_back(c);
    endtask

    task automatic push_encode(input logic [SYM_W-1:0] sym);
        t_command c;
        c           = random_command();
        c.op        = OP_ENCODE;
        c.symbol_in = sym;
        commands_to_send.push_back(c);
    endtask

    task automatic push_decode(input logic b);
        t_command c;
        c        = random_command();
        c.op     = OP_DECODE;
        c.bit_in = b;
        commands_to_send.push_back(c);
    endtask

    task automatic push_end();
        t_command c;
        c    = random_command();
        c.op = OP_END;
        commands_to_send.push_back(c);
    endtask

    // Grow a prefix code by splitting leaves, then load it into random slots
    task automatic build_prefix_table(input int leaves, input bit chain);
        int slot_order[SLOTS];
        int pick;
        int swap_at;
        int tmp;
        leaf_code[0] = '0;
        leaf_len[0]  = '0;
        leaf_count   = 1;
        while (leaf_count < leaves) begin
            // chain mode always splits the deepest leaf to reach long codes
            pick = chain ? leaf_count - 1 : $urandom_range(0, leaf_count - 1);
            leaf_code[leaf_count] = {leaf_code[pick][CODE_W-2:0], 1'b1};
            leaf_len[leaf_count]  = leaf_len[pick] + 1'b1;
            leaf_code[pick]       = {leaf_code[pick][CODE_W-2:0], 1'b0};
            leaf_len[pick]        = leaf_len[pick] + 1'b1;
            leaf_count++;
        end
        for (int s = 0; s < SLOTS; s++) slot_order[s] = s;
        for (int s = SLOTS - 1; s > 0; s--) begin
            swap_at             = $urandom_range(0, s);
            tmp                 = slot_order[s];
            slot_order[s]       = slot_order[swap_at];
            slot_order[swap_at] = tmp;
        end
        for (int k = 0; k < leaf_count; k++) begin
            leaf_sym[k] = SYM_W'($urandom);
            push_load(slot_order[k], leaf_sym[k], leaf_code[k], leaf_len[k]);
        end
    endtask

    // Drive command beats in bursts with random gaps
    always @(posedge i_clk) begin : sender
        t_command next_cmd;
        logic     hold_beat;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            hold_beat = in_ch.valid && !in_ch.ready;
            if (!hold_beat) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (commands_to_send.size() != 0) begin
                    next_cmd = commands_to_send.pop_front();
                    in_ch.op           <= next_cmd.op;
                    in_ch.entry_index  <= next_cmd.entry_index;
                    in_ch.entry_symbol <= next_cmd.entry_symbol;
                    in_ch.entry_code   <= next_cmd.entry_code;
                    in_ch.entry_length <= next_cmd.entry_length;
                    in_ch.symbol_in    <= next_cmd.symbol_in;
                    in_ch.bit_in       <= next_cmd.bit_in;
                    in_ch.valid        <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(30, 80) : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel on changing patterns, with long hold-offs
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (results_taken >= next_hold_at) begin
                // back up the block until it refuses command beats
                next_hold_at = results_taken + HOLD_SPACING;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                if (pace_left == 0) begin
                    pace_left = $urandom_range(8, 60);
                    pace_mode = t_pace'($urandom_range(0, 3));
                end else begin
                    pace_left--;
                end
                case (pace_mode)
                    PACE_FREE:   out_ch.ready <= 1'b1;
                    PACE_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    PACE_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
                    default:     out_ch.ready <= pace_left[1];
                endcase
            end
        end
    end

    // Check result beats, then predict from command beats of the same edge
    always @(posedge i_clk) begin : monitor
        t_reply   seen;
        t_reply   want;
        t_command taken;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen.kind        = t_kind'(out_ch.kind);
                seen.code_word   = out_ch.code_word;
                seen.code_length = out_ch.code_length;
                seen.symbol_out  = out_ch.symbol_out;
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind %0d code %h len %0d sym %h",
                                 $realtime, out_ch.kind, seen.code_word, seen.code_length,
                                 seen.symbol_out);
                end else begin
                    want = replies_due.pop_front();
                    if (seen.kind !== want.kind || seen.code_word !== want.code_word ||
                        seen.code_length !== want.code_length ||
                        seen.symbol_out !== want.symbol_out) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $write("%0t: mismatch: expected kind %0d code %h len %0d sym %h",
                                   $realtime, want.kind, want.code_word, want.code_length,
                                   want.symbol_out);
                            $display(", got kind %0d code %h len %0d sym %h",
                                     out_ch.kind, seen.code_word, seen.code_length,
                                     seen.symbol_out);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                taken.op           = t_op'(in_ch.op);
                taken.entry_index  = in_ch.entry_index;
                taken.entry_symbol = in_ch.entry_symbol;
                taken.entry_code   = in_ch.entry_code;
                taken.entry_length = in_ch.entry_length;
                taken.symbol_in    = in_ch.symbol_in;
                taken.bit_in       = in_ch.bit_in;
                compute_codec_reply(taken);
            end
            // count cycles without any beat for the watchdog
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : run_control
        int roll;
        int runs;
        int pick;
        logic [CODE_W-1:0] long_code;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = '0;
        in_ch.entry_index  = '0;
        in_ch.entry_symbol = '0;
        in_ch.entry_code   = '0;
        in_ch.entry_length = '0;
        in_ch.symbol_in    = '0;
        in_ch.bit_in       = 1'b0;
        out_ch.ready       = 1'b0;

        // Directed: empty table, duplicates, clears, saturation, end marker
        push_end();
        push_encode(8'h00);
        push_load(0, 8'h41, 32'h0, 6'd1);
        push_load(31, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        push_load(1, 8'h41, 32'h1, 6'd1);
        push_load(2, 8'h00, 32'h2, 6'd2);
        push_encode(8'h41);
        push_encode(8'hFF);
        push_end();
        push_decode(1'b0);
        push_decode(1'b1);
        push_load(1, 8'h41, 32'h1, 6'd0);
        push_encode(8'h41);
        push_load(0, 8'h41, 32'h0, 6'd0);
        push_encode(8'h41);
        // other ops between decode bits leave the partial code alone
        push_decode(1'b1);
        push_encode(8'hFF);
        push_end();
        push_load(3, 8'h7E, 32'h3, 6'd32);
        push_decode(1'b0);
        push_load(31, 8'h00, 32'h0, 6'd0);
        push_end();
        push_encode(8'h00);

        // Random: mostly well-formed code streams over loaded tables
        runs = commands_to_send.size() + RANDOM_ITEMS;
        build_prefix_table($urandom_range(2, 12), 1'b0);
        while (commands_to_send.size() < runs) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // wipe the table, overflow the decoder, then reload
                for (int s = 0; s < SLOTS; s++)
                    push_load(s, SYM_W'($urandom), $urandom, 6'd0);
                repeat ($urandom_range(32, 40)) push_decode(1'($urandom));
                build_prefix_table($urandom_range(2, 16), 1'b0);
            end else if (roll < 18) begin
                if ($urandom_range(0, 3) == 0)
                    build_prefix_table($urandom_range(2, SLOTS), 1'b1);
                else
                    build_prefix_table($urandom_range(2, 16), 1'b0);
            end else if (roll < 55) begin
                repeat ($urandom_range(5, 30)) begin
                    pick = $urandom_range(0, leaf_count - 1);
                    for (int b = int'(leaf_len[pick]) - 1; b >= 0; b--)
                        push_decode(leaf_code[pick][b]);
                    if ($urandom_range(0, 15) == 0) push_decode(1'($urandom));
                end
            end else if (roll < 78) begin
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 3) != 0)
                        push_encode(leaf_sym[$urandom_range(0, leaf_count - 1)]);
                    else
                        push_encode(SYM_W'($urandom));
                end
            end else if (roll < 86) begin
                // full-width code word, loaded and then sent bit by bit
                long_code = $urandom;
                push_load($urandom_range(0, SLOTS - 1), SYM_W'($urandom), long_code,
                          ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(33, 63)) :
                                                        CODE_MAX_LEN);
                for (int b = CODE_W - 1; b >= 0; b--) push_decode(long_code[b]);
            end else begin
                repeat ($urandom_range(5, 15)) commands_to_send.push_back(random_command());
                push_end();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        while ((commands_to_send.size() != 0 || in_ch.valid || replies_due.size() != 0) &&
               idle_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, replies_due.size());
            $display("RESULT: ERROR");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (mismatch_count == 0 && replies_due.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### prefix_code_table_codec_unit.f
hdl/pctc_pkg.sv
hdl/pctc_if.sv
hdl/pctc_front.sv
hdl/pctc_queue.sv
hdl/pctc_back.sv
hdl/prefix_code_table_codec_unit.sv
tb/sv/testbench.sv
